// File: hdl/skc_pkg.sv
// Package for the keystream XOR cipher: generator constants, datapath
// operation codes and the command and status structs.
// No dependencies.
package skc_pkg;

    // Generator and seeding constants.
    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;

    // Register indexes on the configuration port.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HASH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_HASH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGINAL_SIZE = 2'd2;

    // Bytes in one key word.
    localparam logic [3:0] KEY_BYTES = 4'd8;

    // Datapath operation codes issued by the controller.
    localparam int unsigned OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
    localparam logic [OP_W-1:0] OP_SEED0 = 4'd1;
    localparam logic [OP_W-1:0] OP_SEED1 = 4'd2;
    localparam logic [OP_W-1:0] OP_SEED2 = 4'd3;
    localparam logic [OP_W-1:0] OP_SEED3 = 4'd4;
    localparam logic [OP_W-1:0] OP_ADV   = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL0  = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL1  = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL2  = 4'd8;
    localparam logic [OP_W-1:0] OP_MUL3  = 4'd9;
    localparam logic [OP_W-1:0] OP_MIXA  = 4'd10;
    localparam logic [OP_W-1:0] OP_MIXB  = 4'd11;
    localparam logic [OP_W-1:0] OP_BYTE  = 4'd12;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            use_mul_b;
    } skc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_start;
        logic key_empty;
        logic out_free;
    } skc_status_t;

endpackage

// File: hdl/skc_datapath.sv
// Datapath of the keystream XOR cipher: configuration registers, generator
// state, a shared 32x32 multiplier with accumulator, key word and output stage.
// Depends on skc_pkg.
module skc_datapath
    import skc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  skc_cmd_t             cmd,
    output skc_status_t          status,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_payload,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_last
);

    logic [63:0] key_hash_reg, key_hash_next;
    logic [63:0] path_hash_reg, path_hash_next;
    logic [63:0] orig_size_reg, orig_size_next;
    logic [63:0] gen_reg, gen_next;
    logic [63:0] key_word_reg, key_word_next;
    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic        at_start_reg, at_start_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] z_reg, z_next;
    logic [63:0] prod_reg, prod_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;

    logic [63:0] mul_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] gen_step;

    // Configuration writes; an index beyond the list is ignored.
    always_comb
    begin
        key_hash_next  = key_hash_reg;
        path_hash_next = path_hash_reg;
        orig_size_next = orig_size_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_HASH:      key_hash_next  = cfg_data;
                REG_PATH_HASH:     path_hash_next = cfg_data;
                REG_ORIGINAL_SIZE: orig_size_next = cfg_data;
                default:           key_hash_next  = key_hash_reg;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    assign mul_const = cmd.use_mul_b ? MIX_MUL_B : MIX_MUL_A;
    assign mul_a     = (cmd.op == OP_MUL2) ? z_reg[63:32] : z_reg[31:0];
    assign mul_b     = (cmd.op == OP_MUL1) ? mul_const[63:32] : mul_const[31:0];
    assign mul_p     = {32'd0, mul_a} * {32'd0, mul_b};
    assign gen_step  = gen_reg + GOLDEN_GAMMA;

    // Operation decode.
    always_comb
    begin
        gen_next        = gen_reg;
        key_word_next   = key_word_reg;
        bytes_left_next = bytes_left_reg;
        at_start_next   = at_start_reg;
        acc_next        = acc_reg;
        z_next          = z_reg;
        prod_next       = prod_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        case (cmd.op)
            OP_SEED0:
            begin
                acc_next = path_hash_reg + GOLDEN_GAMMA;
            end
            OP_SEED1:
            begin
                acc_next = acc_reg + {key_hash_reg[57:0], 6'd0};
            end
            OP_SEED2:
            begin
                acc_next = acc_reg + {2'd0, key_hash_reg[63:2]};
            end
            OP_SEED3:
            begin
                gen_next        = key_hash_reg ^ acc_reg ^ (orig_size_reg + MIX_MUL_A);
                key_word_next   = '0;
                bytes_left_next = '0;
                at_start_next   = 1'b0;
            end
            OP_ADV:
            begin
                gen_next = gen_step;
                z_next   = gen_step ^ {30'd0, gen_step[63:30]};
            end
            OP_MUL0:
            begin
                prod_next = mul_p;
            end
            OP_MUL1:
            begin
                acc_next  = prod_reg;
                prod_next = mul_p;
            end
            OP_MUL2:
            begin
                acc_next  = acc_reg + {prod_reg[31:0], 32'd0};
                prod_next = mul_p;
            end
            OP_MUL3:
            begin
                acc_next = acc_reg + {prod_reg[31:0], 32'd0};
            end
            OP_MIXA:
            begin
                z_next = acc_reg ^ {27'd0, acc_reg[63:27]};
            end
            OP_MIXB:
            begin
                key_word_next   = acc_reg ^ {31'd0, acc_reg[63:31]};
                bytes_left_next = KEY_BYTES;
            end
            OP_BYTE:
            begin
                out_byte_next   = data_byte ^ key_word_reg[7:0];
                out_last_next   = end_of_payload;
                out_valid_next  = 1'b1;
                key_word_next   = {8'd0, key_word_reg[63:8]};
                bytes_left_next = bytes_left_reg - 4'd1;
                if (end_of_payload)
                begin
                    at_start_next = 1'b1;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hash_reg   <= '0;
            path_hash_reg  <= '0;
            orig_size_reg  <= '0;
            gen_reg        <= '0;
            key_word_reg   <= '0;
            bytes_left_reg <= '0;
            at_start_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            key_hash_reg   <= key_hash_next;
            path_hash_reg  <= path_hash_next;
            orig_size_reg  <= orig_size_next;
            gen_reg        <= gen_next;
            key_word_reg   <= key_word_next;
            bytes_left_reg <= bytes_left_next;
            at_start_reg   <= at_start_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        z_reg        <= z_next;
        prod_reg     <= prod_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign status.at_start  = at_start_reg;
    assign status.key_empty = (bytes_left_reg == 4'd0);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

// File: hdl/skc_controller.sv
// Controller of the keystream XOR cipher: sequences seeding, the generator
// step with its two multiplications, and byte acceptance.
// Depends on skc_pkg.
module skc_controller
    import skc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  skc_status_t status,
    input  logic        in_valid,
    output logic        in_ready,
    output skc_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SEED1 = 4'd1;
    localparam logic [3:0] ST_SEED2 = 4'd2;
    localparam logic [3:0] ST_SEED3 = 4'd3;
    localparam logic [3:0] ST_MUL0  = 4'd4;
    localparam logic [3:0] ST_MUL1  = 4'd5;
    localparam logic [3:0] ST_MUL2  = 4'd6;
    localparam logic [3:0] ST_MUL3  = 4'd7;
    localparam logic [3:0] ST_MIXA  = 4'd8;
    localparam logic [3:0] ST_MIXB  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       pass_reg, pass_next;

    // A request is taken only when idle and seeded, a key byte is ready and the output stage is free.
    assign in_ready = (state_reg == ST_IDLE) && !status.at_start && !status.key_empty
                      && status.out_free;

    // Next state and command.
    always_comb
    begin
        state_next    = state_reg;
        pass_next     = pass_reg;
        cmd.op        = OP_NONE;
        cmd.use_mul_b = pass_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.at_start)
                begin
                    // Seed only once a request is waiting, so that late register
                    // writes are still picked up.
                    if (in_valid)
                    begin
                        cmd.op     = OP_SEED0;
                        state_next = ST_SEED1;
                    end
                end
                else if (status.key_empty)
                begin
                    cmd.op     = OP_ADV;
                    pass_next  = 1'b0;
                    state_next = ST_MUL0;
                end
                else if (in_valid && in_ready)
                begin
                    cmd.op = OP_BYTE;
                end
            end
            ST_SEED1:
            begin
                cmd.op     = OP_SEED1;
                state_next = ST_SEED2;
            end
            ST_SEED2:
            begin
                cmd.op     = OP_SEED2;
                state_next = ST_SEED3;
            end
            ST_SEED3:
            begin
                cmd.op     = OP_SEED3;
                state_next = ST_IDLE;
            end
            ST_MUL0:
            begin
                cmd.op     = OP_MUL0;
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.op     = OP_MUL3;
                state_next = pass_reg ? ST_MIXB : ST_MIXA;
            end
            ST_MIXA:
            begin
                cmd.op     = OP_MIXA;
                pass_next  = 1'b1;
                state_next = ST_MUL0;
            end
            ST_MIXB:
            begin
                cmd.op     = OP_MIXB;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

// File: hdl/splitmix_keystream_xor_cipher.sv
// Top level of the keystream XOR cipher: joins the controller and datapath.
// Depends on skc_pkg, skc_controller and skc_datapath.
//
//  Channel   Handshake               Payload
//  input     in_valid / in_ready     data_byte[7:0], end_of_payload
//  output    out_valid / out_ready   out_byte[7:0], out_last
//  config    cfg_write               cfg_index[1:0], cfg_data[63:0]
//
// A byte is taken whenever the current key word has bytes left and the
// output stage is free. A new key word takes one generator step, two
// multiplications on a shared 32x32 multiplier and two mixing steps, and
// the first byte of a payload adds seeding before it. Reset leaves the block
// ready to seed; a stalled output holds its byte and blocks further requests
// until it is taken.
module splitmix_keystream_xor_cipher
    import skc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_payload,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 out_last,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    skc_cmd_t    cmd;
    skc_status_t status;

    skc_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    skc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .data_byte      (data_byte),
        .end_of_payload (end_of_payload),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .out_last       (out_last)
    );

endmodule

// File: sim/skc_cipher_checker.sv
// Checker for the keystream XOR cipher: watches the configuration port and both
// request channels, predicts each output byte and compares it with the block.
// Depends on skc_pkg for the register indexes and generator constants.
module skc_cipher_checker
    import skc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_payload,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [7:0]           out_byte,
    input  logic                 out_last,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    output int unsigned          errors,
    output int unsigned          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cipher_byte_t;

    // Shadow registers, as last written on the configuration port.
    logic [63:0] key_hash_q;
    logic [63:0] path_hash_q;
    logic [63:0] size_q;

    // Keystream state of the predictor.
    logic [63:0] gen_state;
    logic [63:0] key_word;
    logic [3:0]  key_bytes_left;
    logic        at_start;

    // Output bytes predicted but not yet seen on the output channel.
    cipher_byte_t expected_bytes[$];

    // Mix the three registers into a starting generator state.
    function automatic logic [63:0] seed_value();
        logic [63:0] s;
        s = key_hash_q;
        s = s ^ (path_hash_q + GOLDEN_GAMMA + (s << 6) + (s >> 2));
        s = s ^ (size_q + MIX_MUL_A);
        return s;
    endfunction

    // One SplitMix64 step: advance the generator and return the mixed word.
    function automatic logic [63:0] advance_key_word();
        logic [63:0] z;
        gen_state = gen_state + GOLDEN_GAMMA;
        z = gen_state;
        z = (z ^ (z >> 30)) * MIX_MUL_A;
        z = (z ^ (z >> 27)) * MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    // Encrypt one byte, reseeding at the start of a payload and taking a
    // fresh key word whenever the current one is used up.
    function automatic cipher_byte_t cipher_byte(logic [7:0] data, logic last);
        cipher_byte_t r;
        if (at_start)
        begin
            gen_state      = seed_value();
            key_word       = '0;
            key_bytes_left = '0;
            at_start       = 1'b0;
        end
        if (key_bytes_left == 0)
        begin
            key_word       = advance_key_word();
            key_bytes_left = KEY_BYTES;
        end
        r.data         = data ^ key_word[7:0];
        r.last         = last;
        key_word       = key_word >> 8;
        key_bytes_left = key_bytes_left - 4'd1;
        if (last)
        begin
            at_start = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        cipher_byte_t want;
        cipher_byte_t predicted;
        if (!rst_n)
        begin
            key_hash_q     = '0;
            path_hash_q    = '0;
            size_q         = '0;
            gen_state      = '0;
            key_word       = '0;
            key_bytes_left = '0;
            at_start       = 1'b1;
            expected_bytes.delete();
            errors         = 0;
            pending        = 0;
        end
        else
        begin
            // Register writes; an index with no register behind it is ignored.
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_KEY_HASH:      key_hash_q  = cfg_data;
                    REG_PATH_HASH:     path_hash_q = cfg_data;
                    REG_ORIGINAL_SIZE: size_q      = cfg_data;
                    default:           ;
                endcase
            end

            // Predict before comparing, so that a byte passed straight through
            // in the same cycle still finds its expectation.
            if (in_valid && in_ready)
            begin
                predicted = cipher_byte(data_byte, end_of_payload);
                expected_bytes.insert(expected_bytes.size(), predicted);
            end

            // Compare each accepted output request with the oldest prediction.
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    errors++;
                    $display("[%0t] unexpected output: out_byte %02h, out_last %0b",
                             $time, out_byte, out_last);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.data)
                    begin
                        errors++;
                        $display("[%0t] out_byte mismatch: expected %02h, actual %02h",
                                 $time, want.data, out_byte);
                    end
                    if (out_last !== want.last)
                    begin
                        errors++;
                        $display("[%0t] out_last mismatch: expected %0b, actual %0b",
                                 $time, want.last, out_last);
                    end
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

// File: sim/tb_splitmix_keystream_xor_cipher.sv
// Testbench top for the keystream XOR cipher: clock, reset, register writes,
// byte stimulus with random gaps and output stalls, and the final verdict.
// Depends on skc_pkg, splitmix_keystream_xor_cipher and skc_cipher_checker.
module tb_splitmix_keystream_xor_cipher
    import skc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int N_PHASES         = 16;
    localparam int ITEMS_PER_PHASE  = 100;
    localparam int SETTLE_CYCLES    = 40;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TIMEOUT_NS       = 2_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           data_byte;
    logic                 end_of_payload;
    logic                 out_valid;
    logic                 out_ready;
    logic [7:0]           out_byte;
    logic                 out_last;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    int unsigned errors;
    int unsigned pending;

    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_req;
    // Set per payload to send it with no gaps between requests.
    bit steady_run;

    splitmix_keystream_xor_cipher DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_payload (end_of_payload),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .out_last       (out_last),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    skc_cipher_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_payload (end_of_payload),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .out_last       (out_last),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_run || r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Register values, with the extremes well represented.
    function automatic logic [63:0] pick_reg_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly short payloads, some long ones that run through many key words.
    function automatic int pick_payload_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return 1;
        end
        if (r < 80)
        begin
            return $urandom_range(2, 20);
        end
        if (r < 95)
        begin
            return $urandom_range(21, 64);
        end
        return $urandom_range(65, 200);
    endfunction

    // Offer one byte, hold it until it is taken, then idle for a random gap.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        @(negedge clk);
        in_valid       <= 1'b1;
        data_byte      <= b;
        end_of_payload <= last;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Stop offering, wait for every predicted byte, then give the generator
    // time to finish any key word it started on its own.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Receiver: runs of constant readiness, random readiness and stalls.
    initial
    begin : receiver
        int mode;
        int run_len;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 99);
                if (mode < 25)
                begin
                    run_len = $urandom_range(20, 80);
                    repeat (run_len)
                    begin
                        @(negedge clk);
                        out_ready <= 1'b1;
                    end
                end
                else if (mode < 97)
                begin
                    run_len = $urandom_range(1, 16);
                    repeat (run_len)
                    begin
                        @(negedge clk);
                        out_ready <= ($urandom_range(0, 9) < 7);
                    end
                end
                else
                begin
                    run_len = $urandom_range(40, 150);
                    @(negedge clk);
                    out_ready <= 1'b0;
                    repeat (run_len - 1) @(negedge clk);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        int phase;
        int sent;
        int len;
        int k;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = '0;
        end_of_payload = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        hold_req       = 1'b0;
        steady_run     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Registers at their reset values: a two-byte payload from zero hashes.
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b1);
        settle();

        // All registers at their maximum, and a write to the unused index.
        write_reg(REG_KEY_HASH, '1);
        write_reg(REG_PATH_HASH, '1);
        write_reg(REG_ORIGINAL_SIZE, '1);
        write_reg(REG_UNUSED, 64'h0123_4567_89ab_cdef);

        // One-byte payloads, each one seeding the generator again.
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b1);

        // Nine bytes run into a second key word.
        for (k = 0; k < 9; k++)
        begin
            send_byte(8'h55 ^ 8'(k * 37), k == 8);
        end

        // Key hash changed with a payload still open: the old keystream goes
        // on until the payload ends, and only the next one sees the new key.
        send_byte(8'ha5, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(8'hff, 1'b0);
        settle();
        write_reg(REG_KEY_HASH, '0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b1);
        send_byte(8'hc3, 1'b1);

        // Random phases, each with its own register setting. A phase may end
        // with a payload open, so the next writes land mid-payload.
        for (phase = 0; phase < N_PHASES; phase++)
        begin
            settle();
            if (phase == 0 || $urandom_range(0, 9) < 7)
            begin
                write_reg(REG_KEY_HASH, pick_reg_value());
            end
            if (phase == 0 || $urandom_range(0, 9) < 7)
            begin
                write_reg(REG_PATH_HASH, pick_reg_value());
            end
            if (phase == 0 || $urandom_range(0, 9) < 7)
            begin
                write_reg(REG_ORIGINAL_SIZE, pick_reg_value());
            end
            if ($urandom_range(0, 7) == 0)
            begin
                write_reg(REG_UNUSED, {$urandom, $urandom});
            end
            // Once, the receiver holds off while requests keep coming.
            if (phase == 1)
            begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                len        = pick_payload_len();
                steady_run = ($urandom_range(0, 3) == 0);
                for (k = 0; k < len && sent < ITEMS_PER_PHASE; k++)
                begin
                    send_byte(8'($urandom_range(0, 255)), k == len - 1);
                    sent++;
                end
            end
        end

        settle();
        if (errors == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule
